// ===== rtl/qpe_pkg.sv =====
// ----------------------------------------------------------------------------
// qpe_pkg
// Shared types, opcodes and the color hash for the QOI pixel encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qpe_pkg;

   // pixel and table geometry
   localparam int unsigned ChanWidth    = 8;
   localparam int unsigned SlotWidth    = 6;
   localparam int unsigned TableDepth   = 64;
   localparam int unsigned RunWidth     = 6;
   localparam int unsigned MaxBytes     = 6;
   localparam int unsigned ByteIdxWidth = 3;

   // configuration port
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CcWidth      = 3;

   // register index taken from paddr[2]
   localparam logic REG_CHANNEL_COUNT = 1'b0;

   localparam logic [CcWidth-1:0] CC_RESET = 3'd4;
   localparam logic [CcWidth-1:0] CC_RGB   = 3'd3;

   localparam logic [ChanWidth-1:0] ALPHA_OPAQUE = 8'hFF;

   // chunk opcodes
   localparam logic [ChanWidth-1:0] OP_INDEX = 8'h00;
   localparam logic [ChanWidth-1:0] OP_DIFF  = 8'h40;
   localparam logic [ChanWidth-1:0] OP_LUMA  = 8'h80;
   localparam logic [ChanWidth-1:0] OP_RUN   = 8'hC0;
   localparam logic [ChanWidth-1:0] OP_RGB   = 8'hFE;
   localparam logic [ChanWidth-1:0] OP_RGBA  = 8'hFF;

   localparam logic [RunWidth-1:0] RUN_LIMIT = 6'd62;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
      logic [ChanWidth-1:0] alpha;
   } pixel_type;

   localparam pixel_type PIXEL_RESET = '{red: 8'd0, green: 8'd0, blue: 8'd0,
                                         alpha: 8'hFF};

   // (r*3 + g*5 + b*7 + a*11) mod 64, built from shifts of the low bits
   function automatic logic [SlotWidth-1:0] hash_slot(input pixel_type px);
      logic [SlotWidth-1:0] sum;
      sum = {px.red[4:0], 1'b0} + px.red[5:0]
          + {px.green[3:0], 2'b00} + px.green[5:0]
          + {px.blue[2:0], 3'b000} - px.blue[5:0]
          + {px.alpha[2:0], 3'b000} + {px.alpha[4:0], 1'b0} + px.alpha[5:0];
      return sum;
   endfunction

endpackage : qpe_pkg

`default_nettype wire

// ===== rtl/qpe_intf.sv =====
// ----------------------------------------------------------------------------
// qpe channel interfaces
// Pixel request channel and chunk byte response channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface qpe_pix_if;
   import qpe_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ChanWidth-1:0] red;
   logic [ChanWidth-1:0] green;
   logic [ChanWidth-1:0] blue;
   logic [ChanWidth-1:0] alpha;
   logic                 end_of_image;

   modport source (output valid, red, green, blue, alpha, end_of_image,
                   input ready);
   modport sink   (input valid, red, green, blue, alpha, end_of_image,
                   output ready);
endinterface : qpe_pix_if

interface qpe_byte_if;
   import qpe_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ChanWidth-1:0] out_byte;
   logic                 last_byte;

   modport source (output valid, out_byte, last_byte, input ready);
   modport sink   (input valid, out_byte, last_byte, output ready);
endinterface : qpe_byte_if

`default_nettype wire

// ===== rtl/qoi_pixel_encoder_core.sv =====
// ----------------------------------------------------------------------------
// qoi_pixel_encoder_core
// Path: an accepted pixel is registered into the encode stage, and its chunk
//   bytes are registered into the output serializer before they reach rsp.
// Throughput: one pixel per cycle while each pixel yields at most one byte and
//   rsp is ready; the port moves one byte per cycle, so a pixel with more bytes
//   holds the pipe until it is done. The hash table memory is read once per pixel.
// Reset: synchronous; previous pixel to opaque black, run count to zero,
//   channel_count to 4, all 64 table entries read as zero until written.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_pixel_encoder_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   qpe_pix_if.sink                            req_pix,
   qpe_byte_if.source                         rsp_chunk,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [qpe_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [qpe_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic      [qpe_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                               csr_pready
);
   import qpe_pkg::*;

   // configuration register
   logic [CcWidth-1:0] cc_ff, cc_in;
   logic               csr_wr;

   // incoming pixel
   pixel_type            in_pix;
   logic [SlotWidth-1:0] rd_slot;
   logic                 req_fire;

   // table memory and its valid bits
   logic [31:0]           tbl_mem [TableDepth];
   logic [31:0]           tbl_q_ff;
   logic [TableDepth-1:0] tbl_vld_ff, tbl_vld_in;
   logic                  vld_q_ff;
   logic                  wr_en;
   logic                  fwd_hit_ff;
   pixel_type             fwd_data_ff;

   // encode stage
   logic                 s1_valid_ff, s1_valid_in;
   pixel_type            s1_pix_ff;
   logic                 s1_eoi_ff;
   logic [SlotWidth-1:0] s1_slot_ff;
   logic                 s1_adv;

   // encoder state
   pixel_type           prev_ff, prev_in;
   logic [RunWidth-1:0] run_ff, run_in;

   // encode results
   pixel_type              entry;
   logic                   same, hit, alpha_same;
   logic [RunWidth-1:0]    run_inc;
   logic signed [7:0]      dr, dg, db;
   logic signed [8:0]      drg, dbg;
   logic                   is_diff, is_luma;
   logic                   run_emit;
   logic [ChanWidth-1:0]   run_byte;
   logic [ChanWidth-1:0]   chunk [MaxBytes-1];
   logic [ByteIdxWidth-1:0] chunk_len;
   logic [ChanWidth-1:0]   enc_bytes [MaxBytes];
   logic [ByteIdxWidth-1:0] enc_cnt;

   // output serializer
   logic [ChanWidth-1:0]    ob_ff [MaxBytes];
   logic [ByteIdxWidth-1:0] ob_cnt_ff;
   logic [ByteIdxWidth-1:0] ob_idx_ff, ob_idx_in;
   logic                    ob_valid_ff, ob_valid_in;
   logic                    ob_last, ob_free, rsp_fire;

   // apb register access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == REG_CHANNEL_COUNT);
   assign cc_in      = csr_wr ? csr_pwdata[CcWidth-1:0] : cc_ff;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_CHANNEL_COUNT) begin
         csr_prdata = {{(CsrDataWidth-CcWidth){1'b0}}, cc_ff};
      end
   end

   // alpha forcing and hash of the arriving pixel
   always_comb begin
      in_pix.red   = req_pix.red;
      in_pix.green = req_pix.green;
      in_pix.blue  = req_pix.blue;
      in_pix.alpha = (cc_ff == CC_RGB) ? ALPHA_OPAQUE : req_pix.alpha;
   end

   assign rd_slot       = hash_slot(in_pix);
   assign req_pix.ready = !s1_valid_ff || s1_adv;
   assign req_fire      = req_pix.valid && req_pix.ready;

   // table memory, read-first, one read and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[s1_slot_ff] <= s1_pix_ff;
      end
      if (req_fire) begin
         tbl_q_ff <= tbl_mem[rd_slot];
      end
   end

   // valid bits and write forwarding for a same-slot read in the same cycle
   always_comb begin
      tbl_vld_in = tbl_vld_ff;
      if (wr_en) begin
         tbl_vld_in[s1_slot_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         vld_q_ff    <= tbl_vld_ff[rd_slot];
         fwd_hit_ff  <= wr_en && (s1_slot_ff == rd_slot);
         fwd_data_ff <= s1_pix_ff;
         s1_pix_ff   <= in_pix;
         s1_eoi_ff   <= req_pix.end_of_image;
         s1_slot_ff  <= rd_slot;
      end
   end

   assign entry = fwd_hit_ff ? fwd_data_ff : (vld_q_ff ? pixel_type'(tbl_q_ff) : '0);

   // channel differences against the previous pixel
   assign same       = (s1_pix_ff == prev_ff);
   assign hit        = (entry == s1_pix_ff);
   assign alpha_same = (s1_pix_ff.alpha == prev_ff.alpha);
   assign run_inc    = run_ff + 1'b1;
   assign dr         = s1_pix_ff.red   - prev_ff.red;
   assign dg         = s1_pix_ff.green - prev_ff.green;
   assign db         = s1_pix_ff.blue  - prev_ff.blue;
   assign drg        = {dr[7], dr} - {dg[7], dg};
   assign dbg        = {db[7], db} - {dg[7], dg};
   assign is_diff    = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1)
                       && (db >= -8'sd2) && (db <= 8'sd1);
   assign is_luma    = (dg >= -8'sd32) && (dg <= 8'sd31) && (drg >= -9'sd8)
                       && (drg <= 9'sd7) && (dbg >= -9'sd8) && (dbg <= 9'sd7);

   // run handling and chunk selection
   always_comb begin
      run_in    = run_ff;
      run_emit  = 1'b0;
      run_byte  = OP_RUN;
      chunk_len = '0;
      for (int i = 0; i < MaxBytes - 1; i++) begin
         chunk[i] = '0;
      end

      if (same) begin
         run_in = run_inc;
         if ((run_inc == RUN_LIMIT) || s1_eoi_ff) begin
            run_emit = 1'b1;
            run_byte = OP_RUN | {2'b00, run_ff};
            run_in   = '0;
         end
      end else begin
         run_in   = '0;
         run_emit = (run_ff != '0);
         run_byte = OP_RUN | {2'b00, run_ff - 1'b1};
         if (hit) begin
            chunk[0]  = OP_INDEX | {2'b00, s1_slot_ff};
            chunk_len = 3'd1;
         end else if (alpha_same) begin
            if (is_diff) begin
               chunk[0]  = OP_DIFF | {2'b00, dr[1:0] + 2'd2, dg[1:0] + 2'd2,
                                      db[1:0] + 2'd2};
               chunk_len = 3'd1;
            end else if (is_luma) begin
               chunk[0]  = OP_LUMA | {2'b00, dg[5:0] + 6'd32};
               chunk[1]  = {drg[3:0] + 4'd8, dbg[3:0] + 4'd8};
               chunk_len = 3'd2;
            end else begin
               chunk[0]  = OP_RGB;
               chunk[1]  = s1_pix_ff.red;
               chunk[2]  = s1_pix_ff.green;
               chunk[3]  = s1_pix_ff.blue;
               chunk_len = 3'd4;
            end
         end else begin
            chunk[0]  = OP_RGBA;
            chunk[1]  = s1_pix_ff.red;
            chunk[2]  = s1_pix_ff.green;
            chunk[3]  = s1_pix_ff.blue;
            chunk[4]  = s1_pix_ff.alpha;
            chunk_len = 3'd5;
         end
      end
   end

   // byte list: optional run byte ahead of the chunk
   always_comb begin
      enc_bytes[MaxBytes-1] = '0;
      if (run_emit) begin
         enc_bytes[0] = run_byte;
         for (int i = 0; i < MaxBytes - 1; i++) begin
            enc_bytes[i+1] = chunk[i];
         end
         enc_cnt = chunk_len + 1'b1;
      end else begin
         for (int i = 0; i < MaxBytes - 1; i++) begin
            enc_bytes[i] = chunk[i];
         end
         enc_cnt = chunk_len;
      end
   end

   // stage advance and state write-back
   assign s1_adv      = s1_valid_ff && ((enc_cnt == '0) || ob_free);
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_adv);
   assign wr_en       = s1_adv && !same && !hit;
   assign prev_in     = (s1_adv && !same) ? s1_pix_ff : prev_ff;

   // output serializer, one byte per transfer
   assign ob_last   = (ob_idx_ff == ob_cnt_ff - 1'b1);
   assign rsp_fire  = rsp_chunk.valid && rsp_chunk.ready;
   assign ob_free   = !ob_valid_ff || (rsp_chunk.ready && ob_last);

   assign rsp_chunk.valid     = ob_valid_ff;
   assign rsp_chunk.out_byte  = ob_ff[ob_idx_ff];
   assign rsp_chunk.last_byte = ob_last;

   always_comb begin
      ob_valid_in = ob_valid_ff;
      ob_idx_in   = ob_idx_ff;
      if (s1_adv && (enc_cnt != '0)) begin
         ob_valid_in = 1'b1;
         ob_idx_in   = '0;
      end else if (rsp_fire) begin
         if (ob_last) begin
            ob_valid_in = 1'b0;
         end else begin
            ob_idx_in = ob_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && (enc_cnt != '0)) begin
         ob_ff     <= enc_bytes;
         ob_cnt_ff <= enc_cnt;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff       <= CC_RESET;
         tbl_vld_ff  <= '0;
         s1_valid_ff <= 1'b0;
         prev_ff     <= PIXEL_RESET;
         run_ff      <= '0;
         ob_valid_ff <= 1'b0;
         ob_idx_ff   <= '0;
      end else begin
         cc_ff       <= cc_in;
         tbl_vld_ff  <= tbl_vld_in;
         s1_valid_ff <= s1_valid_in;
         prev_ff     <= prev_in;
         run_ff      <= s1_adv ? run_in : run_ff;
         ob_valid_ff <= ob_valid_in;
         ob_idx_ff   <= ob_idx_in;
      end
   end

endmodule : qoi_pixel_encoder_core

`default_nettype wire
